// ===== src/lee_pkg.sv =====
package lee_pkg;

    // fixed field widths
    localparam int CFG_BITS   = 12;
    localparam int PIXEL_BITS = 8;
    localparam int REG_BITS   = 2;

    // parameter defaults
    localparam int COORD_BITS_DEF = 12;
    localparam int OUT_BITS_DEF   = 16;

    // register reset values
    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 12'd960;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 12'd540;
    localparam logic [CFG_BITS-1:0] UPPER_ROW_RST    = 12'd330;

    // register indexes
    localparam logic [REG_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_BITS-1:0] REG_UPPER_ROW    = 2'd2;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CALC,
        BK_SUM,
        BK_DIV_GO,
        BK_DIV_WAIT,
        BK_STORE,
        BK_OUT
    } t_back_st;

    // divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

// ===== src/lane_endpoint_extrapolator_unit.sv =====
// Pixels are taken one per cycle; ready drops only while the two-entry frame queue is full.
// After the end-of-frame item, the shared one-bit-per-cycle divider works out each result,
// run once for each lane side that has both points on distinct rows.
// A frame summary waits in the queue, so the next frame streams in during the divisions.
// Synchronous active-low reset clears the scan counters, flags, queue and sequencer and
// loads the registers with width 960, height 540 and upper row 330.
module lane_endpoint_extrapolator_unit #(
    parameter int COORD_BITS = lee_pkg::COORD_BITS_DEF,
    parameter int OUT_BITS   = lee_pkg::OUT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lee_pkg::REG_BITS-1:0]   i_cfg_addr,
    input  logic [lee_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lee_pkg::PIXEL_BITS-1:0] i_pixel,
    input  logic                           i_end_of_line,
    input  logic                           i_end_of_frame,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [COORD_BITS-1:0]          o_left_top_x,
    output logic [COORD_BITS-1:0]          o_left_top_y,
    output logic signed [OUT_BITS-1:0]     o_left_bottom_x,
    output logic                           o_left_valid,
    output logic [COORD_BITS-1:0]          o_right_top_x,
    output logic [COORD_BITS-1:0]          o_right_top_y,
    output logic signed [OUT_BITS-1:0]     o_right_bottom_x,
    output logic                           o_right_valid,
    output logic [lee_pkg::CFG_BITS-1:0]   o_bottom_row
);
    import lee_pkg::*;

    localparam int MB    = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
    localparam int SUM_W = 2 * (2 + 4 * COORD_BITS) + CFG_BITS;

    logic             q_full, q_empty, q_push, q_pop;
    logic [SUM_W-1:0] front_sum, q_sum;

    // pixel scan and point capture
    lee_front #(
        .CB    (COORD_BITS),
        .MB    (MB),
        .SUM_W (SUM_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .i_end_of_line  (i_end_of_line),
        .i_end_of_frame (i_end_of_frame),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_sum          (front_sum)
    );

    // frame summary queue
    lee_queue #(
        .W (SUM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_sum),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_sum)
    );

    // extrapolation and result register
    lee_back #(
        .CB    (COORD_BITS),
        .MB    (MB),
        .OB    (OUT_BITS),
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sum            (q_sum),
        .i_q_empty        (q_empty),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_left_top_x     (o_left_top_x),
        .o_left_top_y     (o_left_top_y),
        .o_left_bottom_x  (o_left_bottom_x),
        .o_left_valid     (o_left_valid),
        .o_right_top_x    (o_right_top_x),
        .o_right_top_y    (o_right_top_y),
        .o_right_bottom_x (o_right_bottom_x),
        .o_right_valid    (o_right_valid),
        .o_bottom_row     (o_bottom_row)
    );

endmodule

// ===== src/lee_front.sv =====
module lee_front #(
    parameter int CB      = lee_pkg::COORD_BITS_DEF,
    parameter int MB      = 12,
    parameter int SUM_W   = 2 * (2 + 4 * lee_pkg::COORD_BITS_DEF) + lee_pkg::CFG_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lee_pkg::REG_BITS-1:0]  i_cfg_addr,
    input  logic [lee_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lee_pkg::PIXEL_BITS-1:0] i_pixel,
    input  logic                          i_end_of_line,
    input  logic                          i_end_of_frame,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [SUM_W-1:0]              o_sum
);
    import lee_pkg::*;

    localparam int SIDE_W = 2 + 4 * CB;

    logic [CFG_BITS-1:0] r_fw, r_fh, r_ur;
    logic [CB-1:0]       r_col, r_row;
    logic [1:0]          r_hit;
    logic [CB-1:0]       r_hit_col [2];
    logic [1:0]          r_top_f, r_bot_f;
    logic [CB-1:0]       r_top_x [2];
    logic [CB-1:0]       r_top_y [2];
    logic [CB-1:0]       r_bot_x [2];
    logic [CB-1:0]       r_bot_y [2];

    logic                accept, row_end, hit, hit_side, row_ok;
    logic [MB-1:0]       col_e, fw_e, half_e, row_e, fh_e, ur_e;
    logic [1:0]          cur_hit, n_top_f, n_bot_f;
    logic [CB-1:0]       cur_col [2];
    logic [CB-1:0]       n_top_x [2];
    logic [CB-1:0]       n_top_y [2];
    logic [CB-1:0]       n_bot_x [2];
    logic [CB-1:0]       n_bot_y [2];
    logic [SIDE_W-1:0]   side_vec [2];

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign row_end = i_end_of_line || i_end_of_frame;
    assign o_push  = accept && i_end_of_frame;

    // position compares at common width
    assign col_e  = MB'(r_col);
    assign row_e  = MB'(r_row);
    assign fw_e   = MB'(r_fw);
    assign half_e = MB'(r_fw >> 1);
    assign fh_e   = MB'(r_fh);
    assign ur_e   = MB'(r_ur);
    assign hit      = (i_pixel != '0) && (col_e < fw_e);
    assign hit_side = !(col_e < half_e);
    assign row_ok   = row_e < fh_e;

    // row hit tracking and row finish per half
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            cur_hit[s] = r_hit[s] || (hit && (hit_side == 1'(s)));
            cur_col[s] = (hit && (hit_side == 1'(s))) ? r_col : r_hit_col[s];
            n_top_f[s] = r_top_f[s];
            n_top_x[s] = r_top_x[s];
            n_top_y[s] = r_top_y[s];
            n_bot_f[s] = r_bot_f[s];
            n_bot_x[s] = r_bot_x[s];
            n_bot_y[s] = r_bot_y[s];
            if (cur_hit[s] && row_ok) begin
                if (!r_top_f[s] && (row_e >= ur_e)) begin
                    n_top_f[s] = 1'b1;
                    n_top_x[s] = cur_col[s];
                    n_top_y[s] = r_row;
                end
                if (row_e > ur_e) begin
                    n_bot_f[s] = 1'b1;
                    n_bot_x[s] = cur_col[s];
                    n_bot_y[s] = r_row;
                end
            end
            side_vec[s] = {n_top_f[s], n_bot_f[s], n_top_x[s], n_top_y[s],
                           n_bot_x[s], n_bot_y[s]};
        end
    end

    // frame summary handed to the queue
    assign o_sum = {r_fh, side_vec[1], side_vec[0]};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FRAME_WIDTH_RST;
            r_fh <= FRAME_HEIGHT_RST;
            r_ur <= UPPER_ROW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                REG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                REG_UPPER_ROW:    r_ur <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // scan control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_hit   <= '0;
            r_top_f <= '0;
            r_bot_f <= '0;
        end else if (accept) begin
            if (i_end_of_frame) begin
                r_col   <= '0;
                r_row   <= '0;
                r_hit   <= '0;
                r_top_f <= '0;
                r_bot_f <= '0;
            end else if (row_end) begin
                r_col   <= '0;
                r_hit   <= '0;
                r_top_f <= n_top_f;
                r_bot_f <= n_bot_f;
                if (r_row != '1) begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_hit <= cur_hit;
                if (r_col != '1) begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // point payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int s = 0; s < 2; s++) begin
                r_hit_col[s] <= cur_col[s];
                if (row_end) begin
                    r_top_x[s] <= n_top_x[s];
                    r_top_y[s] <= n_top_y[s];
                    r_bot_x[s] <= n_bot_x[s];
                    r_bot_y[s] <= n_bot_y[s];
                end
            end
        end
    end

endmodule

// ===== src/lee_queue.sv =====
module lee_queue #(
    parameter int W = 2 * (2 + 4 * lee_pkg::COORD_BITS_DEF) + lee_pkg::CFG_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    import lee_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/lee_div.sv =====
module lee_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lee_pkg::t_div_ctl i_ctl,
    output lee_pkg::t_div_ctl o_ctl,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    import lee_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   trial, den_e, diff;
    logic             ge;

    // one restoring step per cycle
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign den_e = {1'b0, r_den};
    assign diff  = trial - den_e;
    assign ge    = trial >= den_e;

    assign o_quo        = r_quo;
    assign o_ctl.start  = 1'b0;
    assign o_ctl.done   = r_done;

    // step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

endmodule

// ===== src/lee_back.sv =====
module lee_back #(
    parameter int CB    = lee_pkg::COORD_BITS_DEF,
    parameter int MB    = 12,
    parameter int OB    = lee_pkg::OUT_BITS_DEF,
    parameter int SUM_W = 2 * (2 + 4 * lee_pkg::COORD_BITS_DEF) + lee_pkg::CFG_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [SUM_W-1:0]             i_sum,
    input  logic                         i_q_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [CB-1:0]                o_left_top_x,
    output logic [CB-1:0]                o_left_top_y,
    output logic signed [OB-1:0]         o_left_bottom_x,
    output logic                         o_left_valid,
    output logic [CB-1:0]                o_right_top_x,
    output logic [CB-1:0]                o_right_top_y,
    output logic signed [OB-1:0]         o_right_bottom_x,
    output logic                         o_right_valid,
    output logic [lee_pkg::CFG_BITS-1:0] o_bottom_row
);
    import lee_pkg::*;

    localparam int SIDE_W = 2 + 4 * CB;
    localparam int NUM_W  = 2 * MB + 2;
    localparam logic [NUM_W-1:0] SAT_POS_MAG = NUM_W'((64'd1 << (OB - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] SAT_NEG_MAG = NUM_W'(64'd1 << (OB - 1));
    localparam logic [OB-1:0]    OUT_HI = {1'b0, {(OB - 1){1'b1}}};
    localparam logic [OB-1:0]    OUT_LO = {1'b1, {(OB - 1){1'b0}}};

    t_back_st r_st, n_st;
    t_div_ctl div_in, div_out;

    logic [SUM_W-1:0]        r_sum;
    logic                    r_side;
    logic signed [NUM_W-1:0] r_p1, r_p2;
    logic                    r_den_neg, r_q_neg, r_ok;
    logic [MB-1:0]           r_den_mag;
    logic [NUM_W-1:0]        r_num_mag;
    logic [CB-1:0]           r_tx, r_ty;
    logic [CB-1:0]           r_res_tx [2];
    logic [CB-1:0]           r_res_ty [2];
    logic [OB-1:0]           r_res_bx [2];
    logic [1:0]              r_res_ok;

    logic [SIDE_W-1:0]       side_v;
    logic                    s_top_f, s_bot_f;
    logic [CB-1:0]           s_tx, s_ty, s_bx, s_by, x1, y1;
    logic signed [MB:0]      x1_s, y1_s, x3_s, y3_s, h_s, den_s, dx_s, dh_s, den_abs;
    logic signed [NUM_W-1:0] n_p1, n_p2, num_s, num_abs;
    logic [NUM_W-1:0]        quo;
    logic [OB-1:0]           quo_lo, quo_neg, sat_q;

    // current side fields
    assign side_v  = r_side ? r_sum[2*SIDE_W-1:SIDE_W] : r_sum[SIDE_W-1:0];
    assign s_top_f = side_v[4*CB+1];
    assign s_bot_f = side_v[4*CB];
    assign s_tx    = side_v[4*CB-1:3*CB];
    assign s_ty    = side_v[3*CB-1:2*CB];
    assign s_bx    = side_v[2*CB-1:CB];
    assign s_by    = side_v[CB-1:0];
    assign x1      = s_top_f ? s_tx : '0;
    assign y1      = s_top_f ? s_ty : '0;

    // differences and the two products
    assign x1_s    = $signed({1'b0, MB'(x1)});
    assign y1_s    = $signed({1'b0, MB'(y1)});
    assign x3_s    = $signed({1'b0, MB'(s_bx)});
    assign y3_s    = $signed({1'b0, MB'(s_by)});
    assign h_s     = $signed({1'b0, MB'(r_sum[SUM_W-1:2*SIDE_W])});
    assign den_s   = y1_s - y3_s;
    assign dx_s    = x1_s - x3_s;
    assign dh_s    = h_s - y1_s;
    assign den_abs = den_s[MB] ? -den_s : den_s;
    assign n_p1    = x1_s * den_s;
    assign n_p2    = dh_s * dx_s;

    // numerator sum and magnitude
    assign num_s   = r_p1 + r_p2;
    assign num_abs = num_s[NUM_W-1] ? -num_s : num_s;

    // sign and saturation of the quotient
    assign quo_lo  = quo[OB-1:0];
    assign quo_neg = ~quo_lo + {{(OB - 1){1'b0}}, 1'b1};
    always_comb begin
        if (r_q_neg) begin
            sat_q = (quo > SAT_NEG_MAG) ? OUT_LO : quo_neg;
        end else begin
            sat_q = (quo > SAT_POS_MAG) ? OUT_HI : quo_lo;
        end
    end

    lee_div #(
        .NUM_W (NUM_W),
        .DEN_W (MB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_in),
        .o_ctl   (div_out),
        .i_num   (r_num_mag),
        .i_den   (r_den_mag),
        .o_quo   (quo)
    );

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE:     if (!i_q_empty) n_st = BK_CALC;
            BK_CALC:     n_st = BK_SUM;
            BK_SUM:      n_st = r_ok ? BK_DIV_GO : BK_STORE;
            BK_DIV_GO:   n_st = BK_DIV_WAIT;
            BK_DIV_WAIT: if (div_out.done) n_st = BK_STORE;
            BK_STORE:    n_st = r_side ? BK_OUT : BK_CALC;
            BK_OUT:      if (i_ready) n_st = BK_IDLE;
            default:     n_st = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop        = 1'b0;
        o_valid      = 1'b0;
        div_in.start = 1'b0;
        div_in.done  = 1'b0;
        case (r_st)
            BK_IDLE:   o_pop = !i_q_empty;
            BK_DIV_GO: div_in.start = 1'b1;
            BK_OUT:    o_valid = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= BK_IDLE;
            r_side <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == BK_IDLE) begin
                r_side <= 1'b0;
            end else if (r_st == BK_STORE) begin
                r_side <= 1'b1;
            end
        end
    end

    // per side datapath registers
    always_ff @(posedge i_clk) begin
        case (r_st)
            BK_IDLE: begin
                r_sum <= i_sum;
            end
            BK_CALC: begin
                r_p1      <= n_p1;
                r_p2      <= n_p2;
                r_den_neg <= den_s[MB];
                r_den_mag <= den_abs[MB-1:0];
                r_ok      <= s_top_f && s_bot_f && (y1 != s_by);
                r_tx      <= x1;
                r_ty      <= y1;
            end
            BK_SUM: begin
                r_num_mag <= num_abs;
                r_q_neg   <= num_s[NUM_W-1] ^ r_den_neg;
            end
            BK_STORE: begin
                r_res_tx[r_side] <= r_tx;
                r_res_ty[r_side] <= r_ty;
                r_res_bx[r_side] <= r_ok ? sat_q : '0;
                r_res_ok[r_side] <= r_ok;
            end
            default: ;
        endcase
    end

    // result fields
    assign o_left_top_x     = r_res_tx[0];
    assign o_left_top_y     = r_res_ty[0];
    assign o_left_bottom_x  = r_res_bx[0];
    assign o_left_valid     = r_res_ok[0];
    assign o_right_top_x    = r_res_tx[1];
    assign o_right_top_y    = r_res_ty[1];
    assign o_right_bottom_x = r_res_bx[1];
    assign o_right_valid    = r_res_ok[1];
    assign o_bottom_row     = r_sum[SUM_W-1:2*SIDE_W];

endmodule
